### src/mbps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbps_pkg : shared types and constants of the masked byte pattern scanner
// Payload structs, configuration register indexes and pattern geometry.
// ---------------------------------------------------------------------------
package mbps_pkg;

    // pattern storage is fixed at sixteen bytes
    localparam int PATTERN_SLOTS = 16;
    localparam int SEL_BITS      = $clog2(PATTERN_SLOTS);
    localparam int LEN_BITS      = 5;
    localparam int ADDR_BITS     = 64;
    localparam int CFG_BITS      = 64;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE_ADDRESS   = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_CARE_MASK      = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_REPORT_ALL     = 3'd5
    } t_cfg_idx;

    typedef logic [PATTERN_SLOTS-1:0][7:0] t_pat_bytes;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_scan_in;

    typedef struct packed {
        logic                 match_found;
        logic [ADDR_BITS-1:0] match_address;
        logic                 scan_done;
    } t_scan_out;

    // controls shared by every cell of the window
    typedef struct packed {
        logic                shift;   // take neighbour's byte
        logic                capture; // register compare result
        logic [LEN_BITS-1:0] len;     // effective pattern length
    } t_cell_ctrl;

endpackage

### src/mbps_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbps_cell : one window position of the scanner
// Holds one byte, passes it on to the next older position and compares it
// with the pattern byte that lines up with it for the current length.
// ---------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [7:0]           i_byte,
    input  t_pat_bytes           i_pattern,
    input  logic [PATTERN_SLOTS-1:0] i_care,
    output logic [7:0]           o_byte,
    output logic                 o_eq
);

    logic [7:0]          r_byte;
    logic                r_eq;
    logic                w_in_use;
    logic [SEL_BITS-1:0] w_sel;
    logic                w_eq;

    // position k lines up with pattern byte len-1-k
    always_comb begin
        w_in_use = int'(i_ctrl.len) > CELL_INDEX;
        w_sel    = SEL_BITS'(int'(i_ctrl.len) - 1 - CELL_INDEX);
        w_eq     = !w_in_use || !i_care[w_sel] || (r_byte == i_pattern[w_sel]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
        if (i_ctrl.capture) begin
            r_eq <= w_eq;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = r_eq;

endmodule

### src/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masked_byte_pattern_scanner : wildcard byte signature search over a stream
// Window of byte cells, per-cell compare and a report stage.
// ---------------------------------------------------------------------------
// Takes one byte of a memory region per clock unless the receiver stalls,
// and reports where a pattern of up to 16 bytes, each of which may be a
// wildcard, matches. A byte's result passes the accept, cell compare and
// report registers. The rate is set by the window: every cell shifts and
// compares in parallel each cycle, and the only loop-carried state (byte
// count, first-match flag) is a plain register update. In first-only mode
// one match per region is reported, in all mode every match; the region's
// last byte always yields a transaction with scan_done set. Configuration
// is written through a plain write port, holds until rewritten and must
// be written only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int COUNT_BITS        = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte stream
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_scan_in                i_data,
    // results
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_scan_out               o_data,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    // the longest usable pattern is the smaller of storage and cell count
    localparam int LEN_CAP_INT = (MAX_PATTERN_BYTES < PATTERN_SLOTS)
                                 ? MAX_PATTERN_BYTES : PATTERN_SLOTS;
    localparam logic [LEN_BITS-1:0]   LEN_CAP   = LEN_BITS'(LEN_CAP_INT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [ADDR_BITS-1:0]     r_base;
    logic [63:0]              r_pat_low;
    logic [63:0]              r_pat_high;
    logic [PATTERN_SLOTS-1:0] r_care;
    logic [LEN_BITS-1:0]      r_len;
    logic                     r_report_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_care       <= '1;
            r_len        <= LEN_BITS'(1);
            r_report_all <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_ADDRESS:   r_base       <= i_cfg_data;
                CFG_PATTERN_LOW:    r_pat_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_high   <= i_cfg_data;
                CFG_CARE_MASK:      r_care       <= i_cfg_data[PATTERN_SLOTS-1:0];
                CFG_PATTERN_LENGTH: r_len        <= i_cfg_data[LEN_BITS-1:0];
                CFG_REPORT_ALL:     r_report_all <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [LEN_BITS-1:0] w_len;
    t_pat_bytes          w_pattern;

    assign w_len     = (r_len > LEN_CAP) ? LEN_CAP : r_len;
    assign w_pattern = t_pat_bytes'({r_pat_high, r_pat_low});

    // ---------------------------------------------------------------
    // Pipeline control: accept (A), compare (B), output register.
    // Each stage moves when the next one is empty or moving on.
    // ---------------------------------------------------------------
    logic                  r_a_valid, r_a_last, r_a_placed;
    logic [COUNT_BITS-1:0] r_a_count;
    logic                  r_b_valid, r_b_last, r_b_hit_ok;
    logic [COUNT_BITS-1:0] r_b_offset;
    logic                  r_out_valid;
    t_scan_out             r_out;
    logic [COUNT_BITS-1:0] r_byte_count;
    logic                  r_first;

    logic w_a_load, w_b_load, w_b_move, w_emit, w_match, w_out_free, w_placed;
    logic [MAX_PATTERN_BYTES-1:0] w_eq;
    logic [MAX_PATTERN_BYTES-1:0][7:0] w_cell_byte;
    t_cell_ctrl w_ctrl;

    always_comb begin
        w_out_free = !r_out_valid || i_ready;
        // all cells agree, enough bytes, and the mode allows another report
        w_match    = r_b_hit_ok && (&w_eq) && (r_report_all || !r_first);
        w_emit     = w_match || r_b_last;
        w_b_move   = r_b_valid && (w_out_free || !w_emit);
        w_b_load   = r_a_valid && (!r_b_valid || w_b_move);
        o_ready    = !r_a_valid || w_b_load;
        w_a_load   = i_valid && o_ready;
        w_placed   = (r_byte_count != COUNT_MAX);
    end

    assign w_ctrl = '{shift: w_a_load, capture: w_b_load, len: w_len};

    // the row of window cells; cell 0 holds the newest byte
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic [7:0] w_in_byte;
        if (k == 0) begin : g_head
            assign w_in_byte = i_data.data_byte;
        end else begin : g_link
            assign w_in_byte = w_cell_byte[k-1];
        end
        mbps_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_byte    (w_in_byte),
            .i_pattern (w_pattern),
            .i_care    (r_care),
            .o_byte    (w_cell_byte[k]),
            .o_eq      (w_eq[k])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_byte_count <= '0;
            r_first      <= 1'b0;
        end else begin
            if (w_a_load) begin
                r_a_valid <= 1'b1;
            end else if (w_b_load) begin
                r_a_valid <= 1'b0;
            end

            if (w_b_load) begin
                r_b_valid <= 1'b1;
            end else if (w_b_move) begin
                r_b_valid <= 1'b0;
            end

            if (w_b_move && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // byte count saturates; last byte starts a fresh region
            if (w_a_load) begin
                if (i_data.last_byte) begin
                    r_byte_count <= '0;
                end else if (w_placed) begin
                    r_byte_count <= r_byte_count + COUNT_BITS'(1);
                end
            end

            if (w_b_move) begin
                if (r_b_last) begin
                    r_first <= 1'b0;
                end else if (w_match) begin
                    r_first <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_last   <= i_data.last_byte;
            r_a_placed <= w_placed;
            r_a_count  <= w_placed ? (r_byte_count + COUNT_BITS'(1)) : r_byte_count;
        end
        if (w_b_load) begin
            r_b_last   <= r_a_last;
            r_b_hit_ok <= r_a_placed && (w_len != '0)
                          && (r_a_count >= COUNT_BITS'(w_len));
            r_b_offset <= r_a_count - COUNT_BITS'(w_len);
        end
        if (w_b_move && w_emit) begin
            r_out.match_found   <= w_match;
            r_out.match_address <= w_match ? (r_base + ADDR_BITS'(r_b_offset)) : '0;
            r_out.scan_done     <= r_b_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_nomatch_is_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.match_found) |-> o_data.scan_done)
        else $error("result without match and without scan_done");

    a_nomatch_addr_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.match_found) |-> (o_data.match_address == '0))
        else $error("address set on a result without match");

    a_hit_gate : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !r_b_hit_ok) |-> !w_match)
        else $error("match reported before enough bytes were placed");

    a_count_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_byte_count == COUNT_MAX) && !(w_a_load && i_data.last_byte))
        |=> (r_byte_count == COUNT_MAX))
        else $error("byte count left saturation within a region");

    a_b_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !w_b_move) |=> r_b_valid)
        else $error("compare stage dropped a transaction");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb : self-checking bench for the masked byte pattern scanner
// Streams byte regions through the scanner under random sender gaps and
// receiver stalls. An in-bench model of the window, byte count and
// first-match flag predicts every transaction, which is checked field by
// field in arrival order.
// ---------------------------------------------------------------------------
module tb;
    import mbps_pkg::*;

    localparam int          RANDOM_BYTES = 400;     // bytes in the random part
    localparam int          SETTLE_CYCLES = 6;      // accept, compare, report, margin
    localparam int unsigned CYCLE_LIMIT  = 400000;  // far beyond the slowest run
    localparam int          REPORT_CAP   = 40;      // keep the log readable

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} t_rx_pattern;

    // bench copy of the configuration registers
    typedef struct packed {
        logic [63:0] base_addr;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [15:0] care;
        logic [4:0]  pat_len;
        logic        every_match;
    } t_scan_settings;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            byte_valid = 1'b0;
    logic            byte_ready;
    t_scan_in        scan_item  = '0;
    logic            res_valid;
    logic            res_ready  = 1'b0;
    t_scan_out       res_item;
    logic            cfg_we     = 1'b0;
    t_cfg_idx        cfg_idx    = CFG_BASE_ADDRESS;
    logic [63:0]     cfg_data   = '0;

    // scanner model state
    t_scan_settings  cfg;
    logic [7:0]      scan_window [PATTERN_SLOTS];
    logic [31:0]     bytes_seen;
    logic            match_reported;
    t_scan_out       due_results [$];

    // sender pacing
    int              burst_left  = 0;
    bit              steady_tx   = 1'b0;
    int              items_sent  = 0;
    int              mismatches  = 0;
    int unsigned     cycles      = 0;
    t_rx_pattern     rx_mode     = RX_OPEN;
    int              rx_left     = 0;

    masked_byte_pattern_scanner dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (byte_valid),
        .o_ready    (byte_ready),
        .i_data     (scan_item),
        .o_valid    (res_valid),
        .i_ready    (res_ready),
        .o_data     (res_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Scanner model
    // -----------------------------------------------------------------------

    // window, count and first-match flag back to their start-of-region values
    function automatic void clear_region();
        foreach (scan_window[i]) scan_window[i] = 8'h00;
        bytes_seen     = '0;
        match_reported = 1'b0;
    endfunction

    // one accepted byte: shift it in, test the window, queue any transaction
    function automatic void predict_scan_result(logic [7:0] b, logic lst);
        int unsigned  n;
        bit           placed;
        bit           hit;
        logic [127:0] pat;
        logic [63:0]  addr;
        t_scan_out    due_item;
        n      = (cfg.pat_len > PATTERN_SLOTS) ? PATTERN_SLOTS : cfg.pat_len;
        pat    = {cfg.pat_hi, cfg.pat_lo};
        placed = 1'b0;
        addr   = '0;
        for (int i = PATTERN_SLOTS - 1; i > 0; i--)
            scan_window[i] = scan_window[i-1];
        scan_window[0] = b;
        // the count saturates; a byte that cannot be placed never matches
        if (bytes_seen != '1) begin
            bytes_seen++;
            placed = 1'b1;
        end
        hit = placed && n > 0 && bytes_seen >= n &&
              (cfg.every_match || !match_reported);
        // pattern byte 0 lines up with the oldest of the last n bytes
        for (int j = 0; j < n; j++)
            if (cfg.care[j] && scan_window[n-1-j] !== pat[8*j +: 8])
                hit = 1'b0;
        if (hit) begin
            match_reported = 1'b1;
            addr = cfg.base_addr + (64'(bytes_seen) - 64'(n));
        end
        if (lst)
            clear_region();
        // done on the last byte carries no match unless that byte matched
        if (hit || lst) begin
            due_item = '{match_found: hit, match_address: addr, scan_done: lst};
            due_results = {due_results, due_item};
        end
    endfunction

    // -----------------------------------------------------------------------
    // Receiver: stall pattern of its own, redrawn at random
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_pattern'($urandom_range(0, 2));
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: res_ready <= 1'b1;
            RX_COIN: res_ready <= 1'($urandom_range(0, 1));
            default: res_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // -----------------------------------------------------------------------
    // Checker: each accepted transaction against the oldest prediction
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_scan_out want;
        if (rst_n && res_valid && res_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("transaction with none due: found=%b addr=%h done=%b",
                                          res_item.match_found, res_item.match_address,
                                          res_item.scan_done));
            end else begin
                want = due_results.pop_front();
                if (res_item.match_found !== want.match_found)
                    report_mismatch($sformatf("match_found %b, expected %b",
                                              res_item.match_found, want.match_found));
                if (res_item.match_address !== want.match_address)
                    report_mismatch($sformatf("match_address %h, expected %h",
                                              res_item.match_address, want.match_address));
                if (res_item.scan_done !== want.scan_done)
                    report_mismatch($sformatf("scan_done %b, expected %b",
                                              res_item.scan_done, want.scan_done));
            end
        end
    end

    // hang guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout, %0d transactions still due", due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Shared drivers
    // -----------------------------------------------------------------------

    // one byte in; valid stays high on return so back-to-back bytes never
    // lower and raise it in the same step
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (!steady_tx) begin
            if (burst_left == 0) begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        byte_valid <= 1'b1;
        scan_item  <= '{data_byte: b, last_byte: lst};
        do @(posedge clk); while (!byte_ready);
        predict_scan_result(b, lst);
        items_sent++;
    endtask

    // hold the sender until everything due has arrived and the pipe is empty
    task automatic wait_idle();
        byte_valid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves the write enable high; apply_settings drops it after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_BASE_ADDRESS:   cfg.base_addr   = val;
            CFG_PATTERN_LOW:    cfg.pat_lo      = val;
            CFG_PATTERN_HIGH:   cfg.pat_hi      = val;
            CFG_CARE_MASK:      cfg.care        = val[15:0];
            CFG_PATTERN_LENGTH: cfg.pat_len     = val[4:0];
            CFG_REPORT_ALL:     cfg.every_match = val[0];
            default: ;
        endcase
    endtask

    // all six registers; narrow ones get random junk above their width
    task automatic apply_settings(input t_scan_settings s);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_BASE_ADDRESS,   s.base_addr);
        write_reg(CFG_PATTERN_LOW,    s.pat_lo);
        write_reg(CFG_PATTERN_HIGH,   s.pat_hi);
        write_reg(CFG_CARE_MASK,      {junk[63:16], s.care});
        write_reg(CFG_PATTERN_LENGTH, {junk[63:5], s.pat_len});
        write_reg(CFG_REPORT_ALL,     {junk[63:1], s.every_match});
        cfg_we <= 1'b0;
    endtask

    // background byte: random, a pattern byte, or one of the extremes
    function automatic logic [7:0] fill_byte(logic [127:0] pat);
        int unsigned j;
        j = $urandom_range(0, PATTERN_SLOTS - 1);
        case ($urandom_range(0, 2))
            0:       return 8'($urandom);
            1:       return pat[8*j +: 8];
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // one region, mostly random bytes with copies of the pattern planted in
    // it (wildcard slots random); a noise region plants nothing
    task automatic run_region(input bit closes, input bit noise);
        int unsigned  n;
        int unsigned  eff;
        int unsigned  left;
        int unsigned  pos;
        logic [7:0]   b;
        logic [127:0] pat;
        n    = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(13, 48);
        eff  = (cfg.pat_len > PATTERN_SLOTS) ? PATTERN_SLOTS : cfg.pat_len;
        pat  = {cfg.pat_hi, cfg.pat_lo};
        left = 0;
        pos  = 0;
        for (int k = 0; k < n; k++) begin
            if (!noise && left == 0 && eff > 0 && $urandom_range(0, 3) == 0) begin
                left = eff;
                pos  = 0;
            end
            if (left > 0) begin
                b = cfg.care[pos] ? pat[8*pos +: 8] : fill_byte(pat);
                pos++;
                left--;
            end else begin
                b = fill_byte(pat);
            end
            send_byte(b, closes && (k == n - 1));
        end
    endtask

    // the first few phases sit on the register extremes
    function automatic t_scan_settings pick_settings(int phase);
        t_scan_settings s;
        s.base_addr   = {$urandom, $urandom};
        s.pat_lo      = {$urandom, $urandom};
        s.pat_hi      = {$urandom, $urandom};
        s.care        = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        s.pat_len     = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 6))
                                                   : 5'($urandom_range(0, 31));
        s.every_match = $urandom_range(0, 1);
        case (phase)
            0: begin   // over-long length clamps to the full window, all ones
                s = '{base_addr: '1, pat_lo: '1, pat_hi: '1, care: 16'hFFFF,
                      pat_len: 5'd31, every_match: 1'b1};
            end
            1: begin   // zero length never matches, even fully wildcarded
                s = '{base_addr: '0, pat_lo: '0, pat_hi: '0, care: 16'h0000,
                      pat_len: 5'd0, every_match: 1'b1};
            end
            2: begin   // full-width wildcard: every window from byte 16 on
                s = '{base_addr: '0, pat_lo: '0, pat_hi: '0, care: 16'h0000,
                      pat_len: 5'd16, every_match: 1'b1};
            end
            3: begin   // single wildcard byte, first-only
                s.care        = 16'h0000;
                s.pat_len     = 5'd1;
                s.every_match = 1'b0;
            end
            default: ;
        endcase
        return s;
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // register reset values: one-byte pattern 00, first match only; the
    // final byte matches again but reports done without a match
    task automatic test_default_config();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // regions shorter than the pattern, one of them a single byte
    task automatic test_short_region();
        wait_idle();
        apply_settings('{base_addr: 64'h1000, pat_lo: 64'hEFBE_ADDE,
                         pat_hi: '0, care: 16'hFFFF, pat_len: 5'd4,
                         every_match: 1'b0});
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b1);
        send_byte(8'hBE, 1'b1);
    endtask

    task automatic test_zero_length();
        wait_idle();
        apply_settings('{base_addr: '1, pat_lo: '0, pat_hi: '0, care: 16'h0000,
                         pat_len: 5'd0, every_match: 1'b1});
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // full 16-byte pattern with wildcards, matched on the last byte of the
    // region at offset 1 from an all-ones base, so the address wraps to 0
    task automatic test_long_pattern_wrap();
        logic [127:0] pat;
        logic [15:0]  care;
        pat  = 128'hFF00_A55A_0FF0_00FF_1234_5678_9ABC_FF00;
        care = 16'hF0F5;
        wait_idle();
        apply_settings('{base_addr: '1, pat_lo: pat[63:0], pat_hi: pat[127:64],
                         care: care, pat_len: 5'd16, every_match: 1'b1});
        send_byte(8'hFF, 1'b0);
        for (int j = 0; j < PATTERN_SLOTS; j++)
            send_byte(care[j] ? pat[8*j +: 8] : 8'($urandom), j == PATTERN_SLOTS - 1);
    endtask

    // phases of random regions; a phase may leave its last region open so
    // the next settings land mid-region
    task automatic test_random_regions();
        int phase;
        int regions;
        int start;
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_BYTES) begin
            // sender stops here until every due transaction has come back
            wait_idle();
            apply_settings(pick_settings(phase));
            steady_tx = ($urandom_range(0, 3) == 0);
            regions   = $urandom_range(2, 6);
            for (int r = 0; r < regions; r++)
                run_region(r < regions - 1 || $urandom_range(0, 3) != 0,
                           $urandom_range(0, 4) == 0);
            phase++;
        end
    endtask

    initial begin
        cfg = '{base_addr: '0, pat_lo: '0, pat_hi: '0, care: 16'hFFFF,
                pat_len: 5'd1, every_match: 1'b0};
        clear_region();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_short_region();
        test_zero_length();
        test_long_pattern_wrap();
        test_random_regions();

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
